/* sv/pns_pkg.sv */
`default_nettype none

package pns_pkg;

    // Field widths fixed by the item format.
    localparam int IDX_W   = 8;
    localparam int COMP_W  = 6;
    localparam int ENTRY_W = 3 * COMP_W;
    localparam int LVL_W   = 8;
    localparam int FU_W    = 9;
    localparam int NUM_W   = 14;
    localparam int SQ_W    = 2 * COMP_W;
    localparam int SUM_W   = 14;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register map, indexed by paddr[2].
    localparam logic [0:0] REG_NUM_LIGHTS     = 1'b0;
    localparam logic [0:0] REG_FIRST_UNSHADED = 1'b1;

    localparam logic [LVL_W-1:0] NUM_LIGHTS_RST     = 8'd32;
    localparam logic [FU_W-1:0]  FIRST_UNSHADED_RST = 9'd248;

    // Request kinds.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_rgb;

    // Travels with each palette read of the scan.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_scan_tag;

endpackage

`default_nettype wire

/* sv/pns_palette_ram.sv */
`default_nettype none

module pns_palette_ram
    import pns_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [ENTRY_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/pns_shade_div.sv */
`default_nettype none

module pns_shade_div
    import pns_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [ENTRY_W-1:0] i_src,
    input  wire logic [LVL_W-1:0]   i_count,
    input  wire logic [LVL_W-1:0]   i_level,
    output logic                    o_done,
    output t_rgb                    o_rgb
);

    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;
    localparam logic [2:0] STEP_TOP   = 3'(COMP_W - 1);

    logic               r_busy;
    logic               r_load;
    logic               r_done;
    logic [1:0]         r_comp;
    logic [2:0]         r_step;
    logic [ENTRY_W-1:0] r_src;
    logic [LVL_W-1:0]   r_div;
    logic [LVL_W-1:0]   r_scale;
    logic [NUM_W-1:0]   r_rem;
    logic [COMP_W-1:0]  r_quo;
    t_rgb               r_rgb;

    logic [COMP_W-1:0]  w_comp;
    logic [NUM_W-1:0]   w_num;
    logic [NUM_W-1:0]   w_dsh;
    logic               w_fits;
    logic [NUM_W-1:0]   n_rem;
    logic [COMP_W-1:0]  n_quo;

    // Pick the component being scaled.
    always_comb begin
        unique case (r_comp)
            COMP_RED:   w_comp = r_src[3*COMP_W-1:2*COMP_W];
            COMP_GREEN: w_comp = r_src[2*COMP_W-1:COMP_W];
            COMP_BLUE:  w_comp = r_src[COMP_W-1:0];
            default:    w_comp = '0;
        endcase
    end

    // Scaled numerator with the rounding half added in.
    assign w_num = NUM_W'(NUM_W'(w_comp) * NUM_W'(r_scale)) + NUM_W'(r_div >> 1);

    // One restoring division step: the quotient never exceeds six bits.
    assign w_dsh  = NUM_W'(r_div) << r_step;
    assign w_fits = (r_rem >= w_dsh);
    assign n_rem  = w_fits ? (r_rem - w_dsh) : r_rem;
    assign n_quo  = {r_quo[COMP_W-2:0], w_fits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_done <= 1'b0;
            r_comp <= COMP_RED;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_load  <= 1'b1;
                r_comp  <= COMP_RED;
                r_src   <= i_src;
                r_div   <= i_count;
                r_scale <= i_count - i_level;
            end else if (r_busy) begin
                if (r_load) begin
                    r_rem  <= w_num;
                    r_quo  <= '0;
                    r_step <= STEP_TOP;
                    r_load <= 1'b0;
                end else begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    if (r_step == 3'd0) begin
                        unique case (r_comp)
                            COMP_RED:   r_rgb.red   <= n_quo;
                            COMP_GREEN: r_rgb.green <= n_quo;
                            default:    r_rgb.blue  <= n_quo;
                        endcase
                        if (r_comp == COMP_BLUE) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                            r_load <= 1'b1;
                        end
                    end else begin
                        r_step <= r_step - 3'd1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rgb  = r_rgb;

endmodule

`default_nettype wire

/* sv/pns_nearest_scan.sv */
`default_nettype none

module pns_nearest_scan
    import pns_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_scan_tag          i_tag,
    input  wire logic [ENTRY_W-1:0] i_rdata,
    input  wire t_rgb               i_target,
    output logic                    o_done,
    output logic      [IDX_W-1:0]   o_best
);

    t_scan_tag         r_tag0;
    t_scan_tag         r_tag1;
    logic [SQ_W-1:0]   r_sq_r;
    logic [SQ_W-1:0]   r_sq_g;
    logic [SQ_W-1:0]   r_sq_b;
    logic [SUM_W-1:0]  r_bestd;
    logic [IDX_W-1:0]  r_best;
    logic              r_done;

    logic [COMP_W-1:0] w_dr;
    logic [COMP_W-1:0] w_dg;
    logic [COMP_W-1:0] w_db;
    logic [SUM_W-1:0]  w_sum;

    function automatic logic [COMP_W-1:0] absdiff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Component differences of the entry read this cycle.
    assign w_dr = absdiff(i_rdata[3*COMP_W-1:2*COMP_W], i_target.red);
    assign w_dg = absdiff(i_rdata[2*COMP_W-1:COMP_W], i_target.green);
    assign w_db = absdiff(i_rdata[COMP_W-1:0], i_target.blue);

    assign w_sum = SUM_W'(r_sq_r) + SUM_W'(r_sq_g) + SUM_W'(r_sq_b);

    // Tags follow the memory latency and then the squaring stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
            r_tag1 <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag0 <= i_tag;
            r_tag1 <= r_tag0;
            r_done <= r_tag1.valid & r_tag1.last;
        end
    end

    // Squares of the differences.
    always_ff @(posedge i_clk) begin
        r_sq_r <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_g <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_b <= SQ_W'(w_db) * SQ_W'(w_db);
    end

    // Keep the first entry with the least distance.
    always_ff @(posedge i_clk) begin
        if (r_tag1.valid && (r_tag1.first || (w_sum < r_bestd))) begin
            r_bestd <= w_sum;
            r_best  <= r_tag1.idx;
        end
    end

    assign o_done = r_done;
    assign o_best = r_best;

endmodule

`default_nettype wire

/* sv/palette_shade_nearest_color_top.sv */
// Palette shading by nearest-color search.
//
// Input channel (i_in_valid / o_in_ready): a write request (i_mode = 0) loads
// one palette entry and a query request (i_mode = 1) shades one source color.
// Output channel (o_out_valid / i_out_ready): one result per query, none per
// write. The APB port sets the level count and the first unshaded index; the
// host must write it only while no request is in flight (unenforced).
//
// A write loads the palette entry when it is accepted. A query whose level
// is out of range, or whose color is unshaded, goes straight to the result
// state. A shaded query makes one palette read for the source, passes the
// three components in turn through the shared restoring divider, then makes
// one palette read per entry through a three-stage distance pipeline; the
// palette memory has a single read port.
// Reset clears the control state and the registers; the palette is undefined
// until the host loads it. A stalled receiver leaves the result in the output
// register; the next request is still accepted, and a finished query waits
// for the output register before the block goes idle again.
`default_nettype none

module palette_shade_nearest_color_top
    import pns_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_LEVELS      = 254
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_mode,
    input  wire logic [IDX_W-1:0]   i_color_index,
    input  wire logic [COMP_W-1:0]  i_red,
    input  wire logic [COMP_W-1:0]  i_green,
    input  wire logic [COMP_W-1:0]  i_blue,
    input  wire logic [LVL_W-1:0]   i_light_level,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [IDX_W-1:0]   o_nearest_index,
    output logic                    o_out_of_range,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int               AW       = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0]    LAST_CNT = AW'(PALETTE_ENTRIES - 1);
    localparam logic [FU_W-1:0]  ENTRIES9 = FU_W'(PALETTE_ENTRIES);
    localparam logic [LVL_W-1:0] MAXL     = LVL_W'(MAX_LEVELS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRC   = 6'b000010,
        S_SHADE = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state             r_state;
    logic [LVL_W-1:0]   r_num_lights;
    logic [FU_W-1:0]    r_first_unshaded;
    logic [LVL_W-1:0]   r_count;
    logic [LVL_W-1:0]   r_level;
    logic               r_src_black;
    logic [AW-1:0]      r_scan_cnt;
    logic [IDX_W-1:0]   r_res_idx;
    logic               r_res_oor;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_oor;

    logic               w_in_acc;
    logic               w_cfg_wr;
    logic [LVL_W-1:0]   w_count;
    logic               w_in_store;
    logic               w_we;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [ENTRY_W-1:0] w_src;
    logic               w_div_start;
    logic               w_div_done;
    t_rgb               w_target;
    t_scan_tag          w_tag;
    logic               w_scan_done;
    logic [IDX_W-1:0]   w_best;
    logic               w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_in_store = ({1'b0, i_color_index} < ENTRIES9);
    assign w_out_free = ~r_out_valid | i_out_ready;

    // Effective level count, saturated at the largest supported count.
    assign w_count = (r_num_lights > MAXL) ? MAXL : r_num_lights;

    // Configuration registers.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_lights     <= NUM_LIGHTS_RST;
            r_first_unshaded <= FIRST_UNSHADED_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_NUM_LIGHTS:     r_num_lights     <= pwdata[LVL_W-1:0];
                REG_FIRST_UNSHADED: r_first_unshaded <= pwdata[FU_W-1:0];
                default:            r_num_lights     <= r_num_lights;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_LIGHTS:     prdata = PDATA_W'(r_num_lights);
            REG_FIRST_UNSHADED: prdata = PDATA_W'(r_first_unshaded);
            default:            prdata = '0;
        endcase
    end

    // Palette memory access: writes on request, reads for the source and the scan.
    assign w_we    = w_in_acc & (i_mode == MODE_WRITE) & w_in_store;
    assign w_re    = (w_in_acc & (i_mode == MODE_QUERY)) | (r_state == S_SCAN);
    assign w_raddr = (r_state == S_SCAN) ? r_scan_cnt : i_color_index[AW-1:0];

    pns_palette_ram #(
        .DEPTH (PALETTE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_color_index[AW-1:0]),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Scale the source color.
    assign w_div_start = (r_state == S_SRC);
    assign w_src       = r_src_black ? '0 : w_rdata;

    pns_shade_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_src   (w_src),
        .i_count (r_count),
        .i_level (r_level),
        .o_done  (w_div_done),
        .o_rgb   (w_target)
    );

    // Search the palette for the closest entry.
    assign w_tag.valid = (r_state == S_SCAN);
    assign w_tag.first = (r_scan_cnt == '0);
    assign w_tag.last  = (r_scan_cnt == LAST_CNT);
    assign w_tag.idx   = IDX_W'(r_scan_cnt);

    pns_nearest_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_tag),
        .i_rdata  (w_rdata),
        .i_target (w_target),
        .o_done   (w_scan_done),
        .o_best   (w_best)
    );

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_mode == MODE_QUERY)) begin
                        r_count     <= w_count;
                        r_level     <= i_light_level;
                        r_src_black <= ~w_in_store;
                        if (i_light_level >= w_count) begin
                            r_res_idx <= '0;
                            r_res_oor <= 1'b1;
                            r_state   <= S_DONE;
                        end else if ({1'b0, i_color_index} >= r_first_unshaded) begin
                            r_res_idx <= i_color_index;
                            r_res_oor <= 1'b0;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_SRC;
                        end
                    end
                end
                S_SRC: begin
                    r_state <= S_SHADE;
                end
                S_SHADE: begin
                    if (w_div_done) begin
                        r_scan_cnt <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan_cnt == LAST_CNT) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_scan_cnt <= r_scan_cnt + AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (w_scan_done) begin
                        r_res_idx <= w_best;
                        r_res_oor <= 1'b0;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_idx <= r_res_idx;
            r_out_oor <= r_res_oor;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_idx;
    assign o_out_of_range  = r_out_oor;

    // An out-of-range result always carries index zero.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (o_nearest_index == '0))
        else $error("out-of-range result with nonzero index");

    // The divider finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_SHADE))
        else $error("divider finished outside the shading phase");

    // The scan pipeline finishes only after the last read has been issued.
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_done |-> (r_state == S_DRAIN))
        else $error("scan finished outside the drain phase");

    // A write request leaves the block idle on the next cycle.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_mode == MODE_WRITE)) |=> (r_state == S_IDLE))
        else $error("write request did not return to idle");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pns_pkg::*;

    localparam int PALETTE_ENTRIES = 256;
    localparam int MAX_LEVELS      = 254;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 300;
    localparam int LONG_HOLD       = 3000;
    localparam int PHASE_REQUESTS  = 65;
    localparam int NUM_PHASES      = 6;

    // One request on the input channel.
    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  idx;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [LVL_W-1:0]  level;
    } t_shade_req;

    // One result on the output channel.
    typedef struct packed {
        logic [IDX_W-1:0] nearest;
        logic             oor;
    } t_shade_res;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // One row of the directed table: a request or a register write.
    typedef struct {
        t_row_kind   kind;
        t_shade_req  req;
        bit          typed;
        t_shade_res  known;
        logic [0:0]  reg_sel;
        int unsigned reg_val;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_mode;
    logic [IDX_W-1:0]   i_color_index;
    logic [COMP_W-1:0]  i_red;
    logic [COMP_W-1:0]  i_green;
    logic [COMP_W-1:0]  i_blue;
    logic [LVL_W-1:0]   i_light_level;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [IDX_W-1:0]   o_nearest_index;
    logic               o_out_of_range;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow copy of the palette and the registers.
    t_rgb             palette_model [PALETTE_ENTRIES];
    logic [LVL_W-1:0] lights_cfg;
    logic [FU_W-1:0]  unshaded_cfg;

    t_shade_res pending_shades [$];
    t_stim_row  stim_rows [$];

    int  err_count     = 0;
    int  cycle_count   = 0;
    int  hold_requests = 0;
    bit  tx_burst      = 1'b0;
    bit  rx_burst      = 1'b0;

    palette_shade_nearest_color_top #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_LEVELS      (MAX_LEVELS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_color_index   (i_color_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_light_level   (i_light_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_nearest_index (o_nearest_index),
        .o_out_of_range  (o_out_of_range),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Scale one component by (levels - level) / levels, halves rounding up.
    function automatic int unsigned shade_comp(input int unsigned c, input int unsigned levels,
                                               input int unsigned level);
        return (c * (levels - level) + levels / 2) / levels;
    endfunction

    function automatic int unsigned sq_gap(input int unsigned a, input int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    // Expected answer of a query against the current palette and registers.
    function automatic t_shade_res nearest_shade(input logic [IDX_W-1:0] idx,
                                                 input logic [LVL_W-1:0] level);
        t_shade_res  res;
        int unsigned levels;
        int unsigned sr, sg, sb;
        int unsigned d, best_d;
        t_rgb        src;
        levels      = (lights_cfg > MAX_LEVELS) ? MAX_LEVELS : lights_cfg;
        res.nearest = '0;
        res.oor     = 1'b0;
        // The level check takes priority over the unshaded check.
        if (level >= levels) begin
            res.oor = 1'b1;
            return res;
        end
        if (idx >= unshaded_cfg) begin
            res.nearest = idx;
            return res;
        end
        src    = palette_model[idx];
        sr     = shade_comp(src.red, levels, level);
        sg     = shade_comp(src.green, levels, level);
        sb     = shade_comp(src.blue, levels, level);
        best_d = 32'hFFFF_FFFF;
        // Strict less-than keeps the lowest index on a tie.
        for (int t = 0; t < PALETTE_ENTRIES; t++) begin
            d = sq_gap(palette_model[t].red, sr) + sq_gap(palette_model[t].green, sg)
              + sq_gap(palette_model[t].blue, sb);
            if (d < best_d) begin
                best_d      = d;
                res.nearest = IDX_W'(t);
            end
        end
        return res;
    endfunction

    function automatic t_stim_row row_write(input int idx, input int r, input int g, input int b);
        t_stim_row row;
        row.kind      = ROW_REQ;
        row.req.mode  = MODE_WRITE;
        row.req.idx   = IDX_W'(idx);
        row.req.red   = COMP_W'(r);
        row.req.green = COMP_W'(g);
        row.req.blue  = COMP_W'(b);
        row.req.level = '0;
        row.typed     = 1'b0;
        row.known     = '0;
        row.reg_sel   = REG_NUM_LIGHTS;
        row.reg_val   = 0;
        return row;
    endfunction

    function automatic t_stim_row row_query(input int idx, input int level);
        t_stim_row row;
        row           = row_write(idx, 0, 0, 0);
        row.req.mode  = MODE_QUERY;
        row.req.level = LVL_W'(level);
        return row;
    endfunction

    function automatic t_stim_row row_known(input int idx, input int level, input int e_idx,
                                            input bit e_oor);
        t_stim_row row;
        row               = row_query(idx, level);
        row.typed         = 1'b1;
        row.known.nearest = IDX_W'(e_idx);
        row.known.oor     = e_oor;
        return row;
    endfunction

    function automatic t_stim_row row_config(input logic [0:0] sel, input int unsigned val);
        t_stim_row row;
        row         = row_write(0, 0, 0, 0);
        row.kind    = ROW_CFG;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    function automatic int draw_gap();
        return tx_burst ? 0 : $urandom_range(0, 19);
    endfunction

    // Random request: mostly well-formed queries, some writes and out-of-range levels.
    function automatic t_shade_req random_request();
        t_shade_req  req;
        int unsigned levels;
        int unsigned top;
        req.mode  = ($urandom_range(0, 99) < 25) ? MODE_WRITE : MODE_QUERY;
        req.idx   = IDX_W'($urandom_range(0, 255));
        req.red   = COMP_W'($urandom_range(0, 63));
        req.green = COMP_W'($urandom_range(0, 63));
        req.blue  = COMP_W'($urandom_range(0, 63));
        req.level = LVL_W'($urandom_range(0, 253));
        if (req.mode == MODE_QUERY) begin
            levels = (lights_cfg > MAX_LEVELS) ? MAX_LEVELS : lights_cfg;
            top    = (unshaded_cfg > 256) ? 256 : unshaded_cfg;
            if (levels > 0 && $urandom_range(0, 99) < 85)
                req.level = LVL_W'($urandom_range(0, levels - 1));
            if (top > 0 && $urandom_range(0, 99) < 85)
                req.idx = IDX_W'($urandom_range(0, top - 1));
        end
        return req;
    endfunction

    // Offer one request, wait for it to be taken, then record what it should produce.
    task automatic send_request(input t_shade_req req, input int gap, input bit typed,
                                input t_shade_res known);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= req.mode;
        i_color_index <= req.idx;
        i_red         <= req.red;
        i_green       <= req.green;
        i_blue        <= req.blue;
        i_light_level <= req.level;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (req.mode == MODE_WRITE)
            palette_model[req.idx] = '{red: req.red, green: req.green, blue: req.blue};
        else if (typed)
            pending_shades.push_back(known);
        else
            pending_shades.push_back(nearest_shade(req.idx, req.level));
    endtask

    // Let every outstanding result drain, then give a trailing write time to land.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_shades.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_reg(input logic [0:0] sel, input int unsigned value);
        logic [FU_W-1:0] want;
        want     = (sel == REG_NUM_LIGHTS) ? FU_W'(value & 32'hFF) : FU_W'(value & 32'h1FF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (sel == REG_NUM_LIGHTS)
            lights_cfg = want[LVL_W-1:0];
        else
            unshaded_cfg = want;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[FU_W-1:0] !== want) begin
            err_count++;
            if (err_count <= 10)
                $display("register %0d read back 0x%0h, expected 0x%0h", sel, prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_shade(input logic [IDX_W-1:0] got_idx, input logic got_oor);
        t_shade_res want;
        if (pending_shades.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("unexpected result: index %0d out_of_range %0b", got_idx, got_oor);
        end else begin
            want = pending_shades.pop_front();
            if (got_idx !== want.nearest || got_oor !== want.oor) begin
                err_count++;
                if (err_count <= 10)
                    $display("mismatch: expected index %0d oor %0b, got index %0d oor %0b",
                             want.nearest, want.oor, got_idx, got_oor);
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int n;
        int holds_taken;
        holds_taken = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_requests != holds_taken) begin
                holds_taken = hold_requests;
                n = LONG_HOLD;
            end else if (rx_burst) begin
                n = 0;
            end else begin
                n = $urandom_range(0, 19);
            end
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            check_shade(o_nearest_index, o_out_of_range);
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[palette_shade_nearest_color_top] ERROR");
                $finish;
            end
        end
    end

    // Request side: palette load, directed table, then random phases.
    initial begin : stimulus_main
        t_shade_req  req;
        t_stim_row   row;
        int unsigned lights_val;
        int unsigned unshaded_val;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_mode        <= MODE_WRITE;
        i_color_index <= '0;
        i_red         <= '0;
        i_green       <= '0;
        i_blue        <= '0;
        i_light_level <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        lights_cfg   = NUM_LIGHTS_RST;
        unshaded_cfg = FIRST_UNSHADED_RST;
        @(posedge i_clk);

        // Load every palette entry: black at 0, white at 1, a black twin at 2
        // for the tie case, and a run of copies of earlier entries.
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            req.mode  = MODE_WRITE;
            req.idx   = IDX_W'(i);
            req.red   = COMP_W'($urandom_range(0, 63));
            req.green = COMP_W'($urandom_range(0, 63));
            req.blue  = COMP_W'($urandom_range(0, 63));
            req.level = '0;
            if (i == 0 || i == 2)
                {req.red, req.green, req.blue} = '0;
            else if (i == 1)
                {req.red, req.green, req.blue} = '1;
            else if (i >= 100 && i < 110)
                {req.red, req.green, req.blue} = palette_model[i - 50];
            send_request(req, draw_gap(), 1'b0, '0);
        end

        // Directed table; the first rows run with the reset register values.
        stim_rows.push_back(row_known(250, 0, 250, 1'b0));
        stim_rows.push_back(row_known(255, 31, 255, 1'b0));
        stim_rows.push_back(row_known(248, 5, 248, 1'b0));
        stim_rows.push_back(row_query(247, 0));
        stim_rows.push_back(row_known(3, 32, 0, 1'b1));
        stim_rows.push_back(row_known(255, 253, 0, 1'b1));
        stim_rows.push_back(row_known(0, 0, 0, 1'b0));
        stim_rows.push_back(row_known(1, 0, 1, 1'b0));
        stim_rows.push_back(row_known(2, 0, 0, 1'b0));
        stim_rows.push_back(row_query(1, 31));
        // White at half level lands exactly on a rounding half.
        stim_rows.push_back(row_query(1, 16));
        stim_rows.push_back(row_write(3, 63, 0, 0));
        stim_rows.push_back(row_query(3, 0));
        stim_rows.push_back(row_write(255, 63, 63, 63));
        stim_rows.push_back(row_known(255, 0, 255, 1'b0));
        stim_rows.push_back(row_config(REG_NUM_LIGHTS, 1));
        stim_rows.push_back(row_query(5, 0));
        stim_rows.push_back(row_known(5, 1, 0, 1'b1));
        stim_rows.push_back(row_config(REG_FIRST_UNSHADED, 0));
        stim_rows.push_back(row_known(4, 0, 4, 1'b0));
        stim_rows.push_back(row_config(REG_NUM_LIGHTS, 254));
        stim_rows.push_back(row_config(REG_FIRST_UNSHADED, 256));
        stim_rows.push_back(row_query(255, 253));
        stim_rows.push_back(row_query(255, 0));
        stim_rows.push_back(row_query(1, 127));

        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.reg_sel, row.reg_val);
            end else begin
                send_request(row.req, draw_gap(), row.typed, row.known);
            end
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            lights_val   = $urandom_range(1, 254);
            unshaded_val = $urandom_range(0, 256);
            unique case (p)
                0: lights_val = 1;
                1: begin
                    lights_val   = 254;
                    unshaded_val = 256;
                end
                2: unshaded_val = 0;
                default: ;
            endcase
            wait_idle();
            write_reg(REG_NUM_LIGHTS, lights_val);
            write_reg(REG_FIRST_UNSHADED, unshaded_val);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            // Long receiver hold-off while requests keep coming.
            if (p == 3) begin
                tx_burst = 1'b1;
                rx_burst = 1'b0;
                hold_requests++;
            end
            // No idling on either side.
            if (p == NUM_PHASES - 1) begin
                tx_burst = 1'b1;
                rx_burst = 1'b1;
            end
            for (int k = 0; k < PHASE_REQUESTS; k++)
                send_request(random_request(), draw_gap(), 1'b0, '0);
        end

        // Drain and report.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_shades.size() == 0) begin
            $display("[palette_shade_nearest_color_top] OK");
        end else begin
            $display("[palette_shade_nearest_color_top] ERROR");
        end
        $finish;
    end

endmodule
